### sv/abt_pkg.sv
// types and codes shared by the array binary tree table
// no dependencies; used by array_binary_tree_table_core
package abt_pkg;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SLOT_W = 7;
  localparam int unsigned DATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOKEY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_OCCUPIED = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MATCH,
    S_CHILD,
    S_HIGH,
    S_FREE,
    S_DONE
  } state_e;

endpackage

### sv/abt_ram.sv
// single write port, single read port slot memory, registered read data
// no dependencies; instantiated by array_binary_tree_table_core
module abt_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 33,
  parameter int unsigned AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/array_binary_tree_table_core.sv
// insert, search and delete match scans check one slot per cycle; the delete scan for the highest
// slot runs downward and stops at the first used slot, at the latest at the match
// throughput: one word at a time; the next word is taken once the result is handed over
// to the output register, which may still hold an earlier result
// reset: control clears at once, then a clearing pass empties every slot
// before the first word is accepted
module array_binary_tree_table_core #(
  parameter int unsigned SLOTS = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [abt_pkg::ACT_W-1:0]   action_i,
  input  logic signed [31:0]          key_i,
  input  logic signed [31:0]          value_i,
  input  logic                        side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [abt_pkg::STAT_W-1:0]  status_o,
  output logic                        found_o,
  output logic [abt_pkg::SLOT_W-1:0]  slot_index_o
);

  localparam int unsigned IDXW  = $clog2(SLOTS);
  localparam int unsigned WIDEW = (IDXW > abt_pkg::SLOT_W) ? IDXW : abt_pkg::SLOT_W;
  localparam int unsigned MEMW  = abt_pkg::DATA_W + 1;
  localparam logic [IDXW-1:0] LAST = IDXW'(SLOTS - 1);

  abt_pkg::state_e state_q, state_d;
  logic [IDXW-1:0] cnt_q, cnt_d;
  logic [IDXW-1:0] m_q, m_d;

  logic [abt_pkg::ACT_W-1:0]  act_q;
  logic [abt_pkg::DATA_W-1:0] key_q, val_q;
  logic                       side_q;

  logic [abt_pkg::STAT_W-1:0] res_status_q, res_status_d;
  logic                       res_found_q, res_found_d;
  logic [IDXW-1:0]            res_slot_q, res_slot_d;

  logic                       out_valid_q;
  logic [abt_pkg::STAT_W-1:0] status_q;
  logic                       found_q;
  logic [abt_pkg::SLOT_W-1:0] slot_q;
  logic [WIDEW-1:0]           res_slot_wide;

  logic            ram_we;
  logic [IDXW-1:0] ram_waddr, ram_raddr;
  logic [MEMW-1:0] ram_wdata, ram_rdata;
  logic                       rd_used;
  logic [abt_pkg::DATA_W-1:0] rd_val;
  logic                       hit;
  logic [IDXW+1:0]            child;
  logic                       in_ready;
  logic                       load_out;

  abt_ram #(
    .DEPTH (SLOTS),
    .WIDTH (MEMW),
    .AW    (IDXW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // memory entry is {used, value}
  assign rd_used = ram_rdata[MEMW-1];
  assign rd_val  = ram_rdata[abt_pkg::DATA_W-1:0];
  assign hit     = rd_used && (rd_val == key_q);
  assign child   = {1'b0, cnt_q, 1'b0} + (IDXW+2)'(1) + (IDXW+2)'(side_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    m_d          = m_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_slot_d   = res_slot_q;
    ram_we       = 1'b0;
    ram_waddr    = cnt_q;
    ram_wdata    = '0;
    ram_raddr    = cnt_q;
    in_ready     = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      abt_pkg::S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_q == LAST) begin
          cnt_d   = '0;
          state_d = abt_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + IDXW'(1);
        end
      end
      abt_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = '0;
        if (in_valid_i) begin
          cnt_d        = '0;
          res_status_d = abt_pkg::ST_OK;
          res_found_d  = 1'b0;
          res_slot_d   = '0;
          if (action_i == abt_pkg::ACT_INSERT || action_i == abt_pkg::ACT_SEARCH ||
              action_i == abt_pkg::ACT_DELETE) begin
            state_d = abt_pkg::S_MATCH;
          end else begin
            res_status_d = abt_pkg::ST_RANGE;
            state_d      = abt_pkg::S_DONE;
          end
        end
      end
      abt_pkg::S_MATCH: begin
        // read data belongs to slot cnt_q; next slot is fetched in the same cycle
        priority if (act_q == abt_pkg::ACT_INSERT && cnt_q == '0 && !rd_used) begin
          ram_we       = 1'b1;
          ram_waddr    = '0;
          ram_wdata    = {1'b1, val_q};
          res_status_d = abt_pkg::ST_OK;
          res_slot_d   = '0;
          state_d      = abt_pkg::S_DONE;
        end else if (hit) begin
          m_d = cnt_q;
          if (act_q == abt_pkg::ACT_SEARCH) begin
            res_status_d = abt_pkg::ST_OK;
            res_found_d  = 1'b1;
            res_slot_d   = cnt_q;
            state_d      = abt_pkg::S_DONE;
          end else if (act_q == abt_pkg::ACT_INSERT) begin
            if (child >= (IDXW+2)'(SLOTS)) begin
              res_status_d = abt_pkg::ST_RANGE;
              res_slot_d   = '0;
              state_d      = abt_pkg::S_DONE;
            end else begin
              ram_raddr = child[IDXW-1:0];
              m_d       = child[IDXW-1:0];
              state_d   = abt_pkg::S_CHILD;
            end
          end else begin
            ram_raddr = LAST;
            cnt_d     = LAST;
            state_d   = abt_pkg::S_HIGH;
          end
        end else if (cnt_q == LAST) begin
          res_status_d = abt_pkg::ST_NOKEY;
          res_slot_d   = '0;
          state_d      = abt_pkg::S_DONE;
        end else begin
          ram_raddr = cnt_q + IDXW'(1);
          cnt_d     = cnt_q + IDXW'(1);
        end
      end
      abt_pkg::S_CHILD: begin
        res_slot_d = m_q;
        if (rd_used) begin
          res_status_d = abt_pkg::ST_OCCUPIED;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = m_q;
          ram_wdata    = {1'b1, val_q};
          res_status_d = abt_pkg::ST_OK;
        end
        state_d = abt_pkg::S_DONE;
      end
      abt_pkg::S_HIGH: begin
        // downward scan, first used slot is the highest
        if (rd_used || cnt_q == '0) begin
          ram_we       = 1'b1;
          ram_waddr    = m_q;
          ram_wdata    = {1'b1, rd_val};
          res_status_d = abt_pkg::ST_OK;
          res_found_d  = 1'b1;
          res_slot_d   = m_q;
          state_d      = abt_pkg::S_FREE;
        end else begin
          ram_raddr = cnt_q - IDXW'(1);
          cnt_d     = cnt_q - IDXW'(1);
        end
      end
      abt_pkg::S_FREE: begin
        // frees the highest slot; wins when it is the matched slot too
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
        state_d   = abt_pkg::S_DONE;
      end
      abt_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = abt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = abt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abt_pkg::S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_slot_wide = WIDEW'(res_slot_q);

  always_ff @(posedge clk_i) begin
    m_q          <= m_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_slot_q   <= res_slot_d;
    if (in_valid_i && in_ready) begin
      act_q  <= action_i;
      key_q  <= key_i;
      val_q  <= value_i;
      side_q <= side_i;
    end
    if (load_out) begin
      status_q <= res_status_q;
      found_q  <= res_found_q;
      slot_q   <= res_slot_wide[abt_pkg::SLOT_W-1:0];
    end
  end

  assign in_ready_o   = in_ready;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_o      = found_q;
  assign slot_index_o = slot_q;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != abt_pkg::S_IDLE)
    else $error("accepted word did not start work");

  a_found_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == abt_pkg::ST_OK)
    else $error("found result with error status");

  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == abt_pkg::ST_NOKEY || status_o == abt_pkg::ST_RANGE)
      |-> slot_index_o == '0)
    else $error("failed result carries a slot");

  a_move_targets_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == abt_pkg::S_HIGH && ram_we |-> ram_waddr == m_q && ram_wdata[MEMW-1])
    else $error("delete move written to wrong slot");
`endif

endmodule
